/* rtl/pfr_pkg.sv */
package pfr_pkg;

    localparam int FRAMES            = 4;
    localparam int PAGES_PER_PROCESS = 512;
    localparam int PROCESSES         = 3;

    localparam int FIDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int PAGE_W  = (PAGES_PER_PROCESS > 1) ? $clog2(PAGES_PER_PROCESS) : 1;
    localparam int PROC_W  = 2;
    localparam int ADDR_W  = 24;
    localparam int FSIZE_W = 16;
    localparam int STAMP_W = 32;
    localparam int FAULT_W = 16;
    localparam int POL_W   = 2;
    localparam int CNT_W   = $clog2(ADDR_W + 1);

    localparam logic [FSIZE_W-1:0] FRAME_SIZE_RESET = FSIZE_W'(1000);

    localparam logic [POL_W-1:0] POL_LRU      = 2'd0;
    localparam logic [POL_W-1:0] POL_REF_USE  = 2'd1;
    localparam logic [POL_W-1:0] POL_REF_LOAD = 2'd2;

    localparam logic CFG_FRAME_SIZE = 1'b0;
    localparam logic CFG_POLICY     = 1'b1;

endpackage

/* rtl/page_frame_replacement_top.sv */
// Page frame allocator: one transaction per access, one result per access. An access is
// taken only while the block is idle and runs through a bit-serial divide of the address
// by frame_size, the frame lookup, posting of the result and a return to idle; on a full
// miss the lookup is followed by a victim scan over the frames after frame 0 on a shared
// 32-bit comparator and an update. A rejected access skips the lookup: an unknown process
// is posted at once, a page out of range after the divide. A finished result waits in the
// output register, and the next access may be taken while it waits. The user must write
// configuration only while idle; the block itself does not enforce it.
module page_frame_replacement_top
    import pfr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [FSIZE_W-1:0] cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [PROC_W-1:0]  process,
    input  logic [ADDR_W-1:0]  virtual_address,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [FIDX_W-1:0]  frame,
    output logic               hit,
    output logic               replaced,
    output logic               out_of_range,
    output logic [FAULT_W-1:0] fault_count
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_LOOK  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_EVICT = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [FSIZE_W-1:0] frame_size_reg;
    logic [POL_W-1:0]   policy_reg;

    logic [PAGE_W-1:0]  frame_page_reg  [FRAMES];
    logic [PROC_W-1:0]  frame_owner_reg [FRAMES];
    logic [FRAMES-1:0]  frame_used_reg;
    logic [FRAMES-1:0]  ref_bit_reg;
    logic [STAMP_W-1:0] use_stamp_reg   [FRAMES];
    logic [STAMP_W-1:0] load_stamp_reg  [FRAMES];
    logic [STAMP_W-1:0] use_clock_reg;
    logic [STAMP_W-1:0] load_clock_reg;
    logic [FAULT_W-1:0] faults_reg;

    logic [PROC_W-1:0]  proc_reg;
    logic [PAGE_W-1:0]  page_reg;
    logic [FIDX_W-1:0]  idx_reg;
    logic [FIDX_W-1:0]  pos_reg;
    logic [STAMP_W-1:0] best_reg;

    // result under construction, kept apart from the waiting output
    logic [FIDX_W-1:0]  wk_frame_reg;
    logic               wk_hit_reg;
    logic               wk_repl_reg;
    logic               wk_oor_reg;

    logic               out_valid_reg;
    logic [FIDX_W-1:0]  res_frame_reg;
    logic               res_hit_reg;
    logic               res_repl_reg;
    logic               res_oor_reg;
    logic [FAULT_W-1:0] res_faults_reg;

    logic               div_start;
    logic               div_done;
    logic [ADDR_W-1:0]  quotient;

    logic               in_acc;
    logic               out_free;
    logic               hit_any, empty_any;
    logic [FIDX_W-1:0]  hit_idx, empty_idx;
    logic               scan_pol, load_pol;
    logic [STAMP_W-1:0] cand_stamp;
    logic               cand_less;

    assign in_acc   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    assign div_start = in_acc && (process < PROC_W'(PROCESSES));

    pfr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (virtual_address),
        .divisor  (frame_size_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // resident page search and first empty frame, all frames side by side
    always_comb
    begin
        hit_any   = 1'b0;
        hit_idx   = '0;
        empty_any = 1'b0;
        empty_idx = '0;
        for (int i = FRAMES - 1; i >= 0; i--)
        begin
            if (frame_used_reg[i] && frame_owner_reg[i] == proc_reg
                && frame_page_reg[i] == page_reg)
            begin
                hit_any = 1'b1;
                hit_idx = FIDX_W'(i);
            end
            if (!frame_used_reg[i])
            begin
                empty_any = 1'b1;
                empty_idx = FIDX_W'(i);
            end
        end
    end

    assign load_pol   = (policy_reg == POL_REF_LOAD);
    assign scan_pol   = (policy_reg == POL_REF_USE) || load_pol;
    assign cand_stamp = load_pol ? load_stamp_reg[idx_reg] : use_stamp_reg[idx_reg];
    assign cand_less  = cand_stamp < best_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                    state_next = div_start ? S_DIV : S_DONE;
            end
            S_DIV:
            begin
                if (div_done)
                    state_next = (quotient >= ADDR_W'(PAGES_PER_PROCESS)) ? S_DONE : S_LOOK;
            end
            S_LOOK:
            begin
                if (hit_any || empty_any)
                    state_next = S_DONE;
                else
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (idx_reg == FIDX_W'(FRAMES - 1))
                    state_next = S_EVICT;
            end
            S_EVICT:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            frame_size_reg <= FRAME_SIZE_RESET;
            policy_reg     <= POL_LRU;
            frame_used_reg <= '0;
            ref_bit_reg    <= '0;
            use_clock_reg  <= '0;
            load_clock_reg <= '0;
            faults_reg     <= '0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < FRAMES; i++)
            begin
                frame_page_reg[i]  <= '0;
                frame_owner_reg[i] <= '0;
                use_stamp_reg[i]   <= '0;
                load_stamp_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FRAME_SIZE: frame_size_reg <= cfg_data;
                    CFG_POLICY:     policy_reg     <= cfg_data[POL_W-1:0];
                    default:        ;
                endcase
            end

            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_LOOK:
                begin
                    if (hit_any)
                    begin
                        use_stamp_reg[hit_idx] <= use_clock_reg + STAMP_W'(1);
                        use_clock_reg          <= use_clock_reg + STAMP_W'(1);
                        ref_bit_reg[hit_idx]   <= 1'b1;
                    end
                    else if (empty_any)
                    begin
                        frame_used_reg[empty_idx]  <= 1'b1;
                        frame_page_reg[empty_idx]  <= page_reg;
                        frame_owner_reg[empty_idx] <= proc_reg;
                        use_stamp_reg[empty_idx]   <= use_clock_reg + STAMP_W'(1);
                        load_stamp_reg[empty_idx]  <= load_clock_reg + STAMP_W'(1);
                        use_clock_reg              <= use_clock_reg + STAMP_W'(1);
                        load_clock_reg             <= load_clock_reg + STAMP_W'(1);
                        if (faults_reg != '1)
                            faults_reg <= faults_reg + FAULT_W'(1);
                    end
                end
                S_SCAN:
                begin
                    // a candidate with its reference bit set loses the bit instead
                    if (cand_less && scan_pol && ref_bit_reg[idx_reg])
                        ref_bit_reg[idx_reg] <= 1'b0;
                end
                S_EVICT:
                begin
                    frame_page_reg[pos_reg]  <= page_reg;
                    frame_owner_reg[pos_reg] <= proc_reg;
                    if (load_pol)
                    begin
                        load_stamp_reg[pos_reg] <= load_clock_reg + STAMP_W'(1);
                        load_clock_reg          <= load_clock_reg + STAMP_W'(1);
                    end
                    else
                    begin
                        use_stamp_reg[pos_reg] <= use_clock_reg + STAMP_W'(1);
                        use_clock_reg          <= use_clock_reg + STAMP_W'(1);
                    end
                    if (faults_reg != '1)
                        faults_reg <= faults_reg + FAULT_W'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    // datapath registers without reset
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    proc_reg     <= process;
                    wk_frame_reg <= '0;
                    wk_hit_reg   <= 1'b0;
                    wk_repl_reg  <= 1'b0;
                    wk_oor_reg   <= !div_start;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    page_reg   <= quotient[PAGE_W-1:0];
                    wk_oor_reg <= (quotient >= ADDR_W'(PAGES_PER_PROCESS));
                end
            end
            S_LOOK:
            begin
                wk_frame_reg <= hit_any ? hit_idx : empty_idx;
                wk_hit_reg   <= hit_any;
                idx_reg      <= FIDX_W'(1);
                pos_reg      <= '0;
                best_reg     <= load_pol ? load_stamp_reg[0] : use_stamp_reg[0];
            end
            S_SCAN:
            begin
                if (cand_less && !(scan_pol && ref_bit_reg[idx_reg]))
                begin
                    best_reg <= cand_stamp;
                    pos_reg  <= idx_reg;
                end
                idx_reg <= idx_reg + FIDX_W'(1);
            end
            S_EVICT:
            begin
                wk_frame_reg <= pos_reg;
                wk_repl_reg  <= 1'b1;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    res_frame_reg  <= wk_frame_reg;
                    res_hit_reg    <= wk_hit_reg;
                    res_repl_reg   <= wk_repl_reg;
                    res_oor_reg    <= wk_oor_reg;
                    res_faults_reg <= faults_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign frame        = res_frame_reg;
    assign hit          = res_hit_reg;
    assign replaced     = res_repl_reg;
    assign out_of_range = res_oor_reg;
    assign fault_count  = res_faults_reg;

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> in_stall)
        else $error("input taken while a transaction is in progress");

    a_oor_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_of_range |-> !hit && !replaced)
        else $error("rejected access reports a hit or an eviction");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> !replaced && frame_used_reg[frame])
        else $error("hit on an empty frame or with an eviction");

    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EVICT |-> frame_used_reg == '1)
        else $error("eviction while an empty frame exists");
`endif

endmodule

/* rtl/pfr_div.sv */
module pfr_div
    import pfr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [ADDR_W-1:0]  dividend,
    input  logic [FSIZE_W-1:0] divisor,
    output logic               done,
    output logic [ADDR_W-1:0]  quotient
);

    logic [FSIZE_W-1:0] rem_reg;
    logic [ADDR_W-1:0]  quo_reg;
    logic [FSIZE_W-1:0] dvs_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [FSIZE_W:0]   rem_sh;
    logic [FSIZE_W+1:0] diff;

    // one quotient bit per cycle, restoring
    assign rem_sh = {rem_reg, quo_reg[ADDR_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ADDR_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= (divisor == '0) ? FSIZE_W'(1) : divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[FSIZE_W+1])
            begin
                rem_reg <= diff[FSIZE_W-1:0];
                quo_reg <= {quo_reg[ADDR_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[FSIZE_W-1:0];
                quo_reg <= {quo_reg[ADDR_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* dv/page_frame_replacement_top_tb.sv */
`timescale 1ns / 100ps

module page_frame_replacement_top_tb;
    import pfr_pkg::*;

    localparam int MAP_DEPTH   = PROCESSES * PAGES_PER_PROCESS;
    localparam int CYCLE_LIMIT = 600000;

    // policy code with no policy of its own, handled as true LRU
    localparam logic [POL_W-1:0] POL_UNUSED = 2'd3;

    typedef struct {
        logic [PROC_W-1:0] proc;
        logic [ADDR_W-1:0] vaddr;
    } access_t;

    typedef struct {
        logic [FIDX_W-1:0]  frame;
        logic               hit;
        logic               replaced;
        logic               oor;
        logic [FAULT_W-1:0] faults;
    } outcome_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic               cfg_index;
    logic [FSIZE_W-1:0] cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [PROC_W-1:0]  process;
    logic [ADDR_W-1:0]  virtual_address;
    logic               out_valid;
    logic               out_stall;
    logic [FIDX_W-1:0]  frame;
    logic               hit;
    logic               replaced;
    logic               out_of_range;
    logic [FAULT_W-1:0] fault_count;

    page_frame_replacement_top u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .process         (process),
        .virtual_address (virtual_address),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .frame           (frame),
        .hit             (hit),
        .replaced        (replaced),
        .out_of_range    (out_of_range),
        .fault_count     (fault_count)
    );

    // allocator shadow state
    logic [FSIZE_W-1:0] cur_frame_size;
    logic [POL_W-1:0]   cur_policy;
    logic               map_valid [MAP_DEPTH];
    logic [FIDX_W-1:0]  map_frame [MAP_DEPTH];
    logic [PAGE_W-1:0]  frm_page  [FRAMES];
    logic [PROC_W-1:0]  frm_owner [FRAMES];
    logic               frm_used  [FRAMES];
    logic [STAMP_W-1:0] use_stamp [FRAMES];
    logic [STAMP_W-1:0] load_stamp[FRAMES];
    logic               ref_flag  [FRAMES];
    logic [STAMP_W-1:0] use_clk;
    logic [STAMP_W-1:0] load_clk;
    logic [FAULT_W-1:0] fault_total;

    access_t  access_q[$];
    outcome_t outcome_q[$];

    int unsigned drv_count, acc_count, res_count, err_count, cycle_count;
    int unsigned hit_count, repl_count, oor_count;
    int unsigned gap_left, burst_left, hold_left, stall_phase;
    bit          hold_done;

    task automatic predict_access(input access_t a, output outcome_t o);
        logic [ADDR_W-1:0]  page;
        logic [STAMP_W-1:0] best, s;
        int                 slot, pos, old;
        bit                 placed;
        page   = ADDR_W'(a.vaddr / ((cur_frame_size == 0) ? 1 : cur_frame_size));
        o      = '{default: '0};
        placed = 0;
        if (a.proc >= PROCESSES || page >= PAGES_PER_PROCESS) begin
            o.oor = 1'b1;
        end
        else begin
            slot = a.proc * PAGES_PER_PROCESS + page;
            if (map_valid[slot]) begin
                o.frame = map_frame[slot];
                use_clk = use_clk + 1;
                use_stamp[o.frame] = use_clk;
                ref_flag[o.frame]  = 1'b1;
                o.hit = 1'b1;
            end
            else begin
                for (int i = 0; i < FRAMES; i++) begin
                    if (!placed && !frm_used[i]) begin
                        o.frame = FIDX_W'(i);
                        frm_used[i] = 1'b1;
                        load_clk = load_clk + 1;
                        load_stamp[i] = load_clk;
                        use_clk = use_clk + 1;
                        use_stamp[i] = use_clk;
                        placed = 1;
                    end
                end
                if (!placed) begin
                    best = (cur_policy == POL_REF_LOAD) ? load_stamp[0] : use_stamp[0];
                    pos  = 0;
                    for (int i = 1; i < FRAMES; i++) begin
                        s = (cur_policy == POL_REF_LOAD) ? load_stamp[i] : use_stamp[i];
                        if (s < best) begin
                            // scan policies pass over referenced frames, clearing the bit
                            if ((cur_policy == POL_REF_USE || cur_policy == POL_REF_LOAD)
                                && ref_flag[i]) begin
                                ref_flag[i] = 1'b0;
                            end
                            else begin
                                best = s;
                                pos  = i;
                            end
                        end
                    end
                    o.frame = FIDX_W'(pos);
                    old = frm_owner[pos] * PAGES_PER_PROCESS + frm_page[pos];
                    map_valid[old] = 1'b0;
                    if (cur_policy == POL_REF_LOAD) begin
                        load_clk = load_clk + 1;
                        load_stamp[pos] = load_clk;
                    end
                    else begin
                        use_clk = use_clk + 1;
                        use_stamp[pos] = use_clk;
                    end
                    o.replaced = 1'b1;
                end
                frm_page[o.frame]  = page[PAGE_W-1:0];
                frm_owner[o.frame] = a.proc;
                map_frame[slot]    = o.frame;
                map_valid[slot]    = 1'b1;
                if (fault_total != '1)
                    fault_total = fault_total + FAULT_W'(1);
            end
        end
        o.faults = fault_total;
    endtask

    function automatic access_t make_access(input logic [FSIZE_W-1:0] fs);
        access_t     a;
        int unsigned r, div, pg;
        longint      addr;
        div = (fs == 0) ? 1 : fs;
        r   = $urandom_range(0, 99);
        if (r < 80) begin
            a.proc = PROC_W'($urandom_range(0, PROCESSES - 1));
            pg     = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 5)
                                                 : $urandom_range(0, PAGES_PER_PROCESS - 1);
            addr   = longint'(pg) * div + $urandom_range(0, div - 1);
            a.vaddr = (addr > 24'hFFFFFF) ? 24'hFFFFFF : addr[ADDR_W-1:0];
        end
        else begin
            a.proc  = (r < 92) ? PROC_W'($urandom_range(0, 3)) : 2'd3;
            a.vaddr = ADDR_W'($urandom);
        end
        return a;
    endfunction

    function automatic access_t mk(input int p, input int unsigned va);
        access_t a;
        a.proc  = PROC_W'(p);
        a.vaddr = ADDR_W'(va);
        return a;
    endfunction

    task automatic write_reg(input logic idx, input logic [FSIZE_W-1:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == CFG_FRAME_SIZE)
            cur_frame_size = val;
        else
            cur_policy = val[POL_W-1:0];
    endtask

    task automatic wait_drained();
        while (access_q.size() != 0 || in_valid || outcome_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // driver: bursts of transactions separated by random gaps
    always @(negedge clk) begin
        if (rst_n && (!in_valid || acc_count == drv_count)) begin
            if (gap_left > 0) begin
                in_valid <= 1'b0;
                gap_left = gap_left - 1;
            end
            else if (access_q.size() != 0) begin
                access_t a;
                a = access_q.pop_front();
                in_valid        <= 1'b1;
                process         <= a.proc;
                virtual_address <= a.vaddr;
                drv_count = drv_count + 1;
                if (burst_left > 0)
                    burst_left = burst_left - 1;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 20);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                end
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern, plus one long hold-off to back up the block
    always @(negedge clk) begin
        if (rst_n) begin
            stall_phase = (cycle_count / 300) % 4;
            if (!hold_done && acc_count >= 150) begin
                hold_done = 1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                out_stall <= 1'b1;
            end
            else begin
                case (stall_phase)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 1) == 0);
                    2: out_stall <= ($urandom_range(0, 9) != 0);
                    default: out_stall <= (cycle_count % 7) < 3;
                endcase
            end
        end
    end

    // input acceptance feeds the predictor; output acceptance is checked
    always @(posedge clk) begin
        if (rst_n) begin
            cycle_count <= cycle_count + 1;
            if (in_valid && !in_stall) begin
                access_t  a;
                outcome_t o;
                a.proc  = process;
                a.vaddr = virtual_address;
                predict_access(a, o);
                outcome_q.push_back(o);
                acc_count = acc_count + 1;
            end
            if (out_valid && !out_stall) begin
                outcome_t e;
                res_count = res_count + 1;
                if (outcome_q.size() == 0) begin
                    err_count = err_count + 1;
                    $display("%0t: unexpected transaction frame=%0d hit=%0d", $time, frame, hit);
                end
                else begin
                    e = outcome_q.pop_front();
                    if (e.frame !== frame || e.hit !== hit || e.replaced !== replaced
                        || e.oor !== out_of_range || e.faults !== fault_count) begin
                        err_count = err_count + 1;
                        $display("%0t: mismatch exp frame=%0d hit=%0d repl=%0d oor=%0d faults=%0d",
                                 $time, e.frame, e.hit, e.replaced, e.oor, e.faults);
                        $display("%0t:          act frame=%0d hit=%0d repl=%0d oor=%0d faults=%0d",
                                 $time, frame, hit, replaced, out_of_range, fault_count);
                    end
                    hit_count  = hit_count + e.hit;
                    repl_count = repl_count + e.replaced;
                    oor_count  = oor_count + e.oor;
                end
            end
            if (cycle_count > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("page_frame_replacement_top test failed");
                $finish;
            end
        end
    end

    initial begin
        logic [FSIZE_W-1:0] fs_list [8];
        logic [POL_W-1:0]   pol_list[8];
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_FRAME_SIZE;
        cfg_data = '0;
        in_valid = 1'b0;
        process = '0;
        virtual_address = '0;
        out_stall = 1'b0;
        cur_frame_size = FRAME_SIZE_RESET;
        cur_policy = POL_LRU;
        foreach (map_valid[i]) begin
            map_valid[i] = 1'b0;
            map_frame[i] = '0;
        end
        for (int i = 0; i < FRAMES; i++) begin
            frm_page[i] = '0;
            frm_owner[i] = '0;
            frm_used[i] = 1'b0;
            use_stamp[i] = '0;
            load_stamp[i] = '0;
            ref_flag[i] = 1'b0;
        end
        use_clk = '0;
        load_clk = '0;
        fault_total = '0;
        drv_count = 0; acc_count = 0; res_count = 0; err_count = 0; cycle_count = 0;
        hit_count = 0; repl_count = 0; oor_count = 0;
        gap_left = 0; burst_left = 0; hold_left = 0; hold_done = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // directed: reset config, range edges, unknown process, fill and evict
        access_q.push_back(mk(0, 0));
        access_q.push_back(mk(0, 0));
        access_q.push_back(mk(0, 24'hFFFFFF));
        access_q.push_back(mk(0, 511999));
        access_q.push_back(mk(0, 512000));
        access_q.push_back(mk(3, 5));
        access_q.push_back(mk(2, 511000));
        access_q.push_back(mk(1, 1999));
        access_q.push_back(mk(1, 2000));
        access_q.push_back(mk(2, 0));
        access_q.push_back(mk(0, 999));
        access_q.push_back(mk(1, 0));
        access_q.push_back(mk(2, 511500));
        access_q.push_back(mk(0, 0));
        access_q.push_back(mk(1, 24'h555555));
        access_q.push_back(mk(2, 24'hAAAAAA));
        wait_drained();

        fs_list  = '{16'd0, 16'd65535, 16'd1, 16'd4096, 16'd3, 16'd1000, 16'd0, 16'd0};
        pol_list = '{POL_REF_USE, POL_REF_LOAD, POL_LRU, POL_REF_USE, POL_REF_LOAD,
                     POL_UNUSED, POL_REF_USE, POL_REF_LOAD};
        fs_list[6]  = FSIZE_W'($urandom_range(1, 65535));
        fs_list[7]  = FSIZE_W'($urandom_range(1, 300));
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(CFG_FRAME_SIZE, fs_list[ph]);
            write_reg(CFG_POLICY, FSIZE_W'(pol_list[ph]));
            for (int n = 0; n < 160; n++)
                access_q.push_back(make_access(cur_frame_size));
            wait_drained();
        end

        $display("%0d accesses checked over 9 settings: %0d hits, %0d evictions, %0d rejected",
                 res_count, hit_count, repl_count, oor_count);
        $display("all replacement policies, frame sizes 0 to 65535, one long output hold-off");
        if (err_count == 0)
            $display("page_frame_replacement_top test passed");
        else
            $display("page_frame_replacement_top test failed");
        $finish;
    end

endmodule
